@@ rtl/microwire_eeprom_read_master_top_defines.svh @@
// assertion macros for the microwire eeprom read master
// used by the rtl files that carry assertions, no other dependencies
`ifndef MICROWIRE_EEPROM_READ_MASTER_TOP_DEFINES_SVH
`define MICROWIRE_EEPROM_READ_MASTER_TOP_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, held off during reset
`define MWR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define MWR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MWR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define MWR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/mwr_pkg.sv @@
// shared types and constants for the microwire eeprom read master
// no dependencies
package mwr_pkg;

  localparam int unsigned CMD_EXTRA_BITS = 5;
  localparam logic [2:0]  READ_OPCODE    = 3'b110;

  localparam logic [3:0] ALEN_RESET = 4'd6;
  localparam logic [7:0] HALF_RESET = 8'd1;

  // configuration register indexes
  localparam logic CFG_ADDRESS_LENGTH    = 1'b0;
  localparam logic CFG_HALF_PERIOD_TICKS = 1'b1;

  // pin levels and status of one tick
  typedef struct packed {
    logic chip_select;
    logic shift_clock;
    logic serial_out;
    logic busy_res;
    logic done_res;
  } mwr_pins_t;

endpackage

@@ rtl/mwr_seq.sv @@
// read sequencer: config registers, phase state and per-tick pin levels
// depends on mwr_pkg and microwire_eeprom_read_master_top_defines.svh
`include "microwire_eeprom_read_master_top_defines.svh"

module mwr_seq #(
  parameter int unsigned MAX_ADDRESS_BITS = 8,
  parameter int unsigned DATA_BITS        = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [7:0]           cfg_wdata,
  input  logic                 advance,
  input  logic                 start_req,
  input  logic [7:0]           location,
  input  logic                 serial_in,
  output mwr_pkg::mwr_pins_t   res_pins,
  output logic [MAX_ADDRESS_BITS+mwr_pkg::CMD_EXTRA_BITS+DATA_BITS-1:0] res_value
);

  localparam int unsigned CMD_W = MAX_ADDRESS_BITS + mwr_pkg::CMD_EXTRA_BITS;
  localparam int unsigned CAP_W = CMD_W + DATA_BITS;
  localparam int unsigned BC_W  = $clog2(CAP_W + 1);
  localparam int unsigned IDX_W = $clog2(CMD_W);
  localparam logic [3:0]  MAX_AL = 4'(MAX_ADDRESS_BITS);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD,
    PH_LOW,
    PH_HIGH,
    PH_TAIL
  } phase_t;

  logic [3:0]       alen_r;
  logic [7:0]       half_r;
  phase_t           phase_r, phase_nxt, ph;
  logic [BC_W-1:0]  bc_r, bc_nxt, bc, bc_dec;
  logic [7:0]       tc_r, tc_nxt, tc, tc_step;
  logic [CMD_W-1:0] cmd_r, cmd_nxt, cmd, cmd_new;
  logic [CAP_W-1:0] cap_r, cap_nxt, cap;

  logic [3:0]       al_sat;
  logic [CMD_W+7:0] loc_wide;
  logic [CMD_W-1:0] loc_mask;
  logic [7:0]       half_eff;
  logic             tick_last;
  logic [BC_W-1:0]  idx_wide;
  logic [IDX_W-1:0] idx;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alen_r <= mwr_pkg::ALEN_RESET;
      half_r <= mwr_pkg::HALF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mwr_pkg::CFG_ADDRESS_LENGTH:    alen_r <= cfg_wdata[3:0];
        mwr_pkg::CFG_HALF_PERIOD_TICKS: half_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // command word for a new read
  always_comb begin
    al_sat   = (alen_r > MAX_AL) ? MAX_AL : alen_r;
    loc_wide = {{CMD_W{1'b0}}, location};
    for (int i = 0; i < CMD_W; i++) begin
      loc_mask[i] = (i < int'(al_sat));
    end
    cmd_new = (CMD_W'(mwr_pkg::READ_OPCODE) << al_sat) | (loc_wide[CMD_W-1:0] & loc_mask);
  end

  always_comb begin
    half_eff  = (half_r == 8'd0) ? 8'd1 : half_r;
    ph        = phase_r;
    bc        = bc_r;
    tc        = tc_r;
    cmd       = cmd_r;
    cap       = cap_r;
    if (phase_r == PH_IDLE && start_req) begin
      ph  = PH_LEAD;
      bc  = BC_W'(al_sat) + BC_W'(mwr_pkg::CMD_EXTRA_BITS + DATA_BITS);
      tc  = '0;
      cmd = cmd_new;
      cap = '0;
    end

    tick_last = ({1'b0, tc} + 9'd1) >= {1'b0, half_eff};
    tc_step   = tick_last ? 8'd0 : tc + 8'd1;
    bc_dec    = (bc != '0) ? bc - BC_W'(1) : bc;
    idx_wide  = bc - BC_W'(DATA_BITS + 1);
    idx       = idx_wide[IDX_W-1:0];

    phase_nxt = ph;
    bc_nxt    = bc;
    tc_nxt    = tc;
    cmd_nxt   = cmd;
    cap_nxt   = cap;
    res_pins  = '0;
    res_value = '0;

    case (ph)
      PH_LEAD: begin
        res_pins.busy_res = 1'b1;
        tc_nxt = tc_step;
        if (tick_last) phase_nxt = PH_LOW;
      end
      PH_LOW, PH_HIGH: begin
        res_pins.chip_select = 1'b1;
        res_pins.busy_res    = 1'b1;
        res_pins.serial_out  = (bc > BC_W'(DATA_BITS)) ? cmd[idx] : 1'b0;
        tc_nxt = tc_step;
        if (ph == PH_LOW) begin
          if (tick_last) phase_nxt = PH_HIGH;
        end else begin
          res_pins.shift_clock = 1'b1;
          if (tick_last) begin
            cap_nxt   = {cap[CAP_W-2:0], serial_in};
            bc_nxt    = bc_dec;
            phase_nxt = (bc_dec != '0) ? PH_LOW : PH_TAIL;
          end
        end
      end
      PH_TAIL: begin
        res_pins.chip_select = 1'b1;
        res_pins.busy_res    = 1'b1;
        tc_nxt = tc_step;
        if (tick_last) begin
          res_pins.done_res = 1'b1;
          res_value = cap;
          phase_nxt = PH_IDLE;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bc_r    <= '0;
      tc_r    <= '0;
      cmd_r   <= '0;
      cap_r   <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      bc_r    <= bc_nxt;
      tc_r    <= tc_nxt;
      cmd_r   <= cmd_nxt;
      cap_r   <= cap_nxt;
    end
  end

  `MWR_ASSERT_NXT(a_done_to_idle, clk, rst_n, advance && res_pins.done_res, phase_r == PH_IDLE, "sequencer not idle after done")
  `MWR_ASSERT_IMP(a_value_only_on_done, clk, rst_n, !res_pins.done_res, res_value == '0, "read value nonzero without done")
  `MWR_ASSERT_IMP(a_so_needs_cs, clk, rst_n, res_pins.serial_out || res_pins.shift_clock, res_pins.chip_select, "serial activity without chip select")
  `MWR_ASSERT_IMP(a_bc_range, clk, rst_n, phase_r != PH_IDLE, bc_r <= BC_W'(CAP_W), "bit counter out of range")

endmodule

@@ rtl/mwr_out.sv @@
// result register between the sequencer and the result channel
// depends on mwr_pkg
module mwr_out #(
  parameter int unsigned VALUE_W = 29
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  mwr_pkg::mwr_pins_t res_pins,
  input  logic [VALUE_W-1:0] res_value,
  input  logic               out_stall,
  output logic               out_valid,
  output mwr_pkg::mwr_pins_t out_pins,
  output logic [VALUE_W-1:0] out_value
);

  logic               valid_r, valid_nxt;
  mwr_pkg::mwr_pins_t pins_r;
  logic [VALUE_W-1:0] value_r;

  assign valid_nxt = load | (valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pins_r  <= res_pins;
      value_r <= res_value;
    end
  end

  assign out_valid = valid_r;
  assign out_pins  = pins_r;
  assign out_value = value_r;

endmodule

@@ rtl/microwire_eeprom_read_master_top.sv @@
// microwire eeprom read master, top level
// depends on mwr_pkg, mwr_seq and mwr_out
//
//   channel  | handshake           | payload
//   ---------+---------------------+----------------------------------------------
//   in       | in_valid/in_stall   | start_req, location, serial_in (one tick)
//   out      | out_valid/out_stall | chip_select, shift_clock, serial_out, busy,
//            |                     | done, read_value (one result per tick)
//   cfg      | cfg_we              | cfg_index, cfg_wdata
//
// one transfer in and one transfer out per sequencer tick, one tick per cycle while in_stall is low;
// a tick's result sits in the result register in the cycle after its transfer in.
// a new tick is held off while the previous result waits in the result register;
// in_stall rises only when that register is full and out_stall is high.
// synchronous active-low reset: idle, address length 6, half period 1.
module microwire_eeprom_read_master_top #(
  parameter int unsigned MAX_ADDRESS_BITS = 8,
  parameter int unsigned DATA_BITS        = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_start_req,
  input  logic [7:0] in_location,
  input  logic       in_serial_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_chip_select,
  output logic       out_shift_clock,
  output logic       out_serial_out,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic [MAX_ADDRESS_BITS+mwr_pkg::CMD_EXTRA_BITS+DATA_BITS-1:0] out_read_value
);

  localparam int unsigned VALUE_W = MAX_ADDRESS_BITS + mwr_pkg::CMD_EXTRA_BITS + DATA_BITS;

  logic               advance;
  mwr_pkg::mwr_pins_t res_pins, out_pins;
  logic [VALUE_W-1:0] res_value;

  assign in_stall = out_valid & out_stall;
  assign advance  = in_valid & ~in_stall;

  mwr_seq #(
    .MAX_ADDRESS_BITS (MAX_ADDRESS_BITS),
    .DATA_BITS        (DATA_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .advance   (advance),
    .start_req (in_start_req),
    .location  (in_location),
    .serial_in (in_serial_in),
    .res_pins  (res_pins),
    .res_value (res_value)
  );

  mwr_out #(
    .VALUE_W (VALUE_W)
  ) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res_pins  (res_pins),
    .res_value (res_value),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_pins  (out_pins),
    .out_value (out_read_value)
  );

  assign out_chip_select = out_pins.chip_select;
  assign out_shift_clock = out_pins.shift_clock;
  assign out_serial_out  = out_pins.serial_out;
  assign out_busy_res    = out_pins.busy_res;
  assign out_done_res    = out_pins.done_res;

endmodule
